// ===== hw/rtl/weighted_union_find_path_compression_defines.svh =====
// Assertion macros shared by the union-find RTL.
`ifndef WEIGHTED_UNION_FIND_PATH_COMPRESSION_DEFINES_SVH
`define WEIGHTED_UNION_FIND_PATH_COMPRESSION_DEFINES_SVH

`ifndef ASSERT_OFF

`define WUFPC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define WUFPC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WUFPC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`define WUFPC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/wufpc_pkg.sv =====
// Types, constants and microcode program of the union-find block.
package wufpc_pkg;

    localparam int unsigned NODES_DEF = 256;
    localparam int unsigned FIELD_W   = 8;
    localparam int unsigned COST_W    = 8;
    localparam int unsigned UPC_W     = 4;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    localparam logic [1:0] COST_ONE    = 2'd1;
    localparam logic [1:0] COST_HOP    = 2'd2;
    localparam logic [1:0] COST_RELINK = 2'd3;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_START,
        OP_FIND,
        OP_COMP,
        OP_SIZE_A,
        OP_SIZE_B,
        OP_LINK,
        OP_OUT,
        OP_CLEAR
    } op_t;

    typedef enum logic {
        SIDE_P,
        SIDE_Q
    } side_t;

    typedef struct packed {
        op_t   op;
        side_t side;
        upc_t  tgt_t;
        upc_t  tgt_f;
    } uword_t;

    localparam upc_t STEP_WAIT     = 4'd0;
    localparam upc_t STEP_P_SEEK   = 4'd1;
    localparam upc_t STEP_P_FIND   = 4'd2;
    localparam upc_t STEP_P_REWIND = 4'd3;
    localparam upc_t STEP_P_COMP   = 4'd4;
    localparam upc_t STEP_Q_SEEK   = 4'd5;
    localparam upc_t STEP_Q_FIND   = 4'd6;
    localparam upc_t STEP_Q_REWIND = 4'd7;
    localparam upc_t STEP_Q_COMP   = 4'd8;
    localparam upc_t STEP_SIZE_P   = 4'd9;
    localparam upc_t STEP_SIZE_Q   = 4'd10;
    localparam upc_t STEP_LINK     = 4'd11;
    localparam upc_t STEP_OUT      = 4'd12;
    localparam upc_t STEP_CLEAR    = 4'd13;

    function automatic uword_t uw(input op_t op, input side_t side,
                                  input upc_t tgt_t, input upc_t tgt_f);
        uword_t w;
        w.op    = op;
        w.side  = side;
        w.tgt_t = tgt_t;
        w.tgt_f = tgt_f;
        return w;
    endfunction

    function automatic uword_t ucode(input upc_t step);
        uword_t w;
        unique case (step)
            STEP_WAIT:     w = uw(OP_WAIT,   SIDE_P, STEP_P_SEEK,   STEP_WAIT);
            STEP_P_SEEK:   w = uw(OP_START,  SIDE_P, STEP_P_FIND,   STEP_P_FIND);
            STEP_P_FIND:   w = uw(OP_FIND,   SIDE_P, STEP_P_REWIND, STEP_P_FIND);
            STEP_P_REWIND: w = uw(OP_START,  SIDE_P, STEP_P_COMP,   STEP_P_COMP);
            STEP_P_COMP:   w = uw(OP_COMP,   SIDE_P, STEP_Q_SEEK,   STEP_P_COMP);
            STEP_Q_SEEK:   w = uw(OP_START,  SIDE_Q, STEP_Q_FIND,   STEP_Q_FIND);
            STEP_Q_FIND:   w = uw(OP_FIND,   SIDE_Q, STEP_Q_REWIND, STEP_Q_FIND);
            STEP_Q_REWIND: w = uw(OP_START,  SIDE_Q, STEP_Q_COMP,   STEP_Q_COMP);
            STEP_Q_COMP:   w = uw(OP_COMP,   SIDE_Q, STEP_SIZE_P,   STEP_Q_COMP);
            STEP_SIZE_P:   w = uw(OP_SIZE_A, SIDE_P, STEP_OUT,      STEP_SIZE_Q);
            STEP_SIZE_Q:   w = uw(OP_SIZE_B, SIDE_Q, STEP_LINK,     STEP_LINK);
            STEP_LINK:     w = uw(OP_LINK,   SIDE_P, STEP_OUT,      STEP_OUT);
            STEP_OUT:      w = uw(OP_OUT,    SIDE_P, STEP_WAIT,     STEP_OUT);
            STEP_CLEAR:    w = uw(OP_CLEAR,  SIDE_P, STEP_WAIT,     STEP_CLEAR);
            default:       w = uw(OP_WAIT,   SIDE_P, STEP_WAIT,     STEP_WAIT);
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/wufpc_req_if.sv =====
// Request and result channel interfaces of the union-find block.
interface wufpc_req_if import wufpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] p_node;
    logic [FIELD_W-1:0] q_node;

    modport source (output valid, output p_node, output q_node, input ready);
    modport sink   (input valid, input p_node, input q_node, output ready);
endinterface

interface wufpc_rsp_if import wufpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               already_connected;
    logic [FIELD_W-1:0] merged_root;
    logic [COST_W-1:0]  access_count;

    modport source (output valid, output already_connected, output merged_root,
                    output access_count, input ready);
    modport sink   (input valid, input already_connected, input merged_root,
                    input access_count, output ready);
endinterface

// ===== hw/rtl/wufpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wufpc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/wufpc_seq.sv =====
// Microcode sequencer: step counter and control word lookup.
module wufpc_seq import wufpc_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cond,
    output uword_t ctrl
);

    upc_t upc_reg;
    upc_t upc_next;

    assign ctrl = ucode(upc_reg);

    always_comb
    begin
        upc_next = cond ? ctrl.tgt_t : ctrl.tgt_f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_CLEAR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== hw/rtl/wufpc_dp.sv =====
// Datapath: parent and size stores, walk registers, cost counter, result register.
`include "weighted_union_find_path_compression_defines.svh"

module wufpc_dp import wufpc_pkg::*; #(
    parameter int unsigned NODES = NODES_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    input  uword_t ctrl,
    output logic   cond,
    wufpc_req_if.sink   req,
    wufpc_rsp_if.source rsp
);

    localparam int unsigned IW = $clog2(NODES);
    localparam int unsigned SW = $clog2(NODES + 1);
    localparam int unsigned LUT_N = 2 ** FIELD_W;

    logic [IW-1:0] wrap_lut [LUT_N];

    for (genvar i = 0; i < LUT_N; i++)
    begin : g_wrap
        localparam int unsigned WRAPPED = i % NODES;
        assign wrap_lut[i] = IW'(WRAPPED);
    end

    logic [IW-1:0]     p_reg, p_next;
    logic [IW-1:0]     q_reg, q_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic [IW-1:0]     root_reg, root_next;
    logic [IW-1:0]     rp_reg, rp_next;
    logic [IW-1:0]     rq_reg, rq_next;
    logic [IW-1:0]     mroot_reg, mroot_next;
    logic [SW-1:0]     sp_reg, sp_next;
    logic [COST_W-1:0] cost_reg, cost_next;
    logic [IW-1:0]     clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_conn_reg, out_conn_next;
    logic [FIELD_W-1:0] out_root_reg, out_root_next;
    logic [COST_W-1:0] out_cost_reg, out_cost_next;

    logic          par_we;
    logic [IW-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
    logic          sz_we;
    logic [IW-1:0] sz_waddr, sz_raddr;
    logic [SW-1:0] sz_wdata, sz_rdata;

    logic [IW-1:0]     start;
    logic              hit;
    logic              same_root;
    logic              p_small;
    logic [SW-1:0]     sz_sum;
    logic [1:0]        cost_add;
    logic [COST_W:0]   cost_sum;
    logic [COST_W-1:0] cost_sat;

    wufpc_ram #(.WIDTH(IW), .DEPTH(NODES)) u_parent (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    wufpc_ram #(.WIDTH(SW), .DEPTH(NODES)) u_size (
        .clk   (clk),
        .we    (sz_we),
        .waddr (sz_waddr),
        .wdata (sz_wdata),
        .raddr (sz_raddr),
        .rdata (sz_rdata)
    );

    assign start     = (ctrl.side == SIDE_Q) ? q_reg : p_reg;
    assign hit       = (par_rdata == cur_reg);
    assign same_root = (rp_reg == rq_reg);
    assign p_small   = (sp_reg < sz_rdata);
    assign sz_sum    = sp_reg + sz_rdata;
    assign cost_sum  = {1'b0, cost_reg} + (COST_W + 1)'(cost_add);
    assign cost_sat  = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];

    assign req.ready             = (ctrl.op == OP_WAIT);
    assign rsp.valid             = out_valid_reg;
    assign rsp.already_connected = out_conn_reg;
    assign rsp.merged_root       = out_root_reg;
    assign rsp.access_count      = out_cost_reg;

    always_comb
    begin
        p_next         = p_reg;
        q_next         = q_reg;
        cur_next       = cur_reg;
        root_next      = root_reg;
        rp_next        = rp_reg;
        rq_next        = rq_reg;
        mroot_next     = mroot_reg;
        sp_next        = sp_reg;
        cost_next      = cost_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_conn_next  = out_conn_reg;
        out_root_next  = out_root_reg;
        out_cost_next  = out_cost_reg;
        par_we         = 1'b0;
        par_waddr      = cur_reg;
        par_wdata      = root_reg;
        par_raddr      = start;
        sz_we          = 1'b0;
        sz_waddr       = clr_reg;
        sz_wdata       = SW'(1);
        sz_raddr       = rp_reg;
        cost_add       = 2'd0;
        cond           = 1'b0;

        unique case (ctrl.op)
            OP_WAIT:
            begin
                cond = req.valid;
                if (req.valid)
                begin
                    p_next    = wrap_lut[req.p_node];
                    q_next    = wrap_lut[req.q_node];
                    cost_next = '0;
                end
            end
            OP_START:
            begin
                cond      = 1'b1;
                cur_next  = start;
                par_raddr = start;
                cost_add  = COST_ONE;
            end
            OP_FIND:
            begin
                cond = hit;
                if (hit)
                begin
                    root_next = cur_reg;
                end
                else
                begin
                    cur_next  = par_rdata;
                    par_raddr = par_rdata;
                    cost_add  = COST_HOP;
                end
            end
            OP_COMP:
            begin
                cond = hit;
                if (hit)
                begin
                    if (ctrl.side == SIDE_Q)
                    begin
                        rq_next = root_reg;
                    end
                    else
                    begin
                        rp_next = root_reg;
                    end
                end
                else
                begin
                    par_we    = 1'b1;
                    par_waddr = cur_reg;
                    par_wdata = root_reg;
                    par_raddr = par_rdata;
                    cur_next  = par_rdata;
                    cost_add  = COST_RELINK;
                end
            end
            OP_SIZE_A:
            begin
                cond     = same_root;
                sz_raddr = rp_reg;
                if (same_root)
                begin
                    mroot_next = rp_reg;
                end
            end
            OP_SIZE_B:
            begin
                cond     = 1'b1;
                sp_next  = sz_rdata;
                sz_raddr = rq_reg;
            end
            OP_LINK:
            begin
                cond     = 1'b1;
                cost_add = COST_ONE;
                par_we   = 1'b1;
                sz_we    = 1'b1;
                sz_wdata = sz_sum;
                if (p_small)
                begin
                    par_waddr  = rp_reg;
                    par_wdata  = rq_reg;
                    sz_waddr   = rq_reg;
                    mroot_next = rq_reg;
                end
                else
                begin
                    par_waddr  = rq_reg;
                    par_wdata  = rp_reg;
                    sz_waddr   = rp_reg;
                    mroot_next = rp_reg;
                end
            end
            OP_OUT:
            begin
                cond = !out_valid_reg || rsp.ready;
                if (cond)
                begin
                    out_valid_next = 1'b1;
                    out_conn_next  = same_root;
                    out_root_next  = FIELD_W'(mroot_reg);
                    out_cost_next  = cost_reg;
                end
            end
            OP_CLEAR:
            begin
                cond      = (clr_reg == IW'(NODES - 1));
                par_we    = 1'b1;
                par_waddr = clr_reg;
                par_wdata = clr_reg;
                sz_we     = 1'b1;
                sz_waddr  = clr_reg;
                sz_wdata  = SW'(1);
                clr_next  = clr_reg + IW'(1);
            end
            default:
            begin
                cond = 1'b0;
            end
        endcase

        if (cost_add != 2'd0)
        begin
            cost_next = cost_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        q_reg        <= q_next;
        cur_reg      <= cur_next;
        root_reg     <= root_next;
        rp_reg       <= rp_next;
        rq_reg       <= rq_next;
        mroot_reg    <= mroot_next;
        sp_reg       <= sp_next;
        cost_reg     <= cost_next;
        out_conn_reg <= out_conn_next;
        out_root_reg <= out_root_next;
        out_cost_reg <= out_cost_next;
    end

    `WUFPC_ASSERT_IMP(a_relink_no_collide, clk, rst_n, (ctrl.op == OP_COMP) && par_we, par_waddr != par_raddr, "relink write collides with path read")
    `WUFPC_ASSERT_IMP(a_link_distinct, clk, rst_n, ctrl.op == OP_LINK, rp_reg != rq_reg, "link step with equal roots")
    `WUFPC_ASSERT_IMP(a_result_from_out, clk, rst_n, $rose(out_valid_reg), $past(ctrl.op == OP_OUT), "result raised outside output step")
    `WUFPC_ASSERT_NXT(a_find_advances, clk, rst_n, (ctrl.op == OP_FIND) && !hit, cur_reg != $past(cur_reg), "find walk did not advance")

endmodule

// ===== hw/rtl/weighted_union_find_path_compression.sv =====
// Top level of the weighted union-find block with full path compression.
// One request beat carries a node pair and yields one result beat. A short microcode
// program steps a datapath around a parent store and a size store, each one RAM with
// one read port; parent links are followed one after another, because the next address
// is the data just read from the parent RAM. Each side is walked to its root and then
// walked again to compress its path, and the two trees are linked by size when their
// roots differ; weighting keeps paths near log2 of the node count. The next request is
// taken once the result sits in the output register, even if it has not yet been taken.
// After reset a clearing pass over all NODES entries loads the identity into the parent
// store and ones into the size store, and no request is taken until it ends.
module weighted_union_find_path_compression import wufpc_pkg::*; #(
    parameter int unsigned NODES = NODES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    wufpc_req_if.sink   req,
    wufpc_rsp_if.source rsp
);

    uword_t ctrl;
    logic   cond;

    wufpc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    wufpc_dp #(.NODES(NODES)) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .cond  (cond),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
